// ----- rtl/core/depth_pixel_back_projection_unit_macros.svh -----
// assertion macros used by the checker file of the back-projection unit
`ifndef DEPTH_PIXEL_BACK_PROJECTION_UNIT_MACROS_SVH
`define DEPTH_PIXEL_BACK_PROJECTION_UNIT_MACROS_SVH

// same-cycle implication, off while reset is high
`define DPBP_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dpbp assertion failed");

// next-cycle implication, off while reset is high
`define DPBP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dpbp assertion failed");

// next-cycle implication that also runs through reset
`define DPBP_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("dpbp assertion failed");

`endif

// ----- rtl/core/dpbp_pkg.sv -----
// types and constants of the depth pixel back-projection unit
package dpbp_pkg;

   localparam int COL_W      = 12;
   localparam int ROW_W      = 12;
   localparam int DEPTH_W    = 16;
   localparam int CHAN_W     = 8;
   localparam int COORD_W    = 32;
   localparam int IN_W       = 64;
   localparam int OUT_W      = 120;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int SCALE_W    = 32;
   localparam int CENTER_W   = 16;
   localparam int FOCAL_W    = 24;

   localparam int ZF_W       = DEPTH_W + SCALE_W;    // q24.24 depth in meters
   localparam int DMAG_W     = 16;                   // |pix*16 - center|
   localparam int AX_W       = DMAG_W + FOCAL_W;     // offset times 1/f
   localparam int ZF_HALF_W  = ZF_W / 2;
   localparam int PP_W       = AX_W + ZF_HALF_W;     // one partial product
   localparam int PROD_W     = AX_W + ZF_W;          // full lateral product
   localparam int FRAC_SHIFT = 36;
   localparam int MAG_W      = PROD_W - FRAC_SHIFT;
   localparam int Z_SHIFT    = 8;
   localparam int ZR_W       = ZF_W + 1;
   localparam int ZQ_W       = ZR_W - Z_SHIFT;
   localparam int Z_MSB      = 95;                   // sign bit of point_z in rsp_tdata

   localparam logic [SCALE_W-1:0]  INV_DEPTH_SCALE_RST = 32'd16777;
   localparam logic [CENTER_W-1:0] CENTER_X_RST        = 16'd5208;
   localparam logic [CENTER_W-1:0] CENTER_Y_RST        = 16'd4056;
   localparam logic [FOCAL_W-1:0]  INV_FOCAL_X_RST     = 24'd32388;
   localparam logic [FOCAL_W-1:0]  INV_FOCAL_Y_RST     = 24'd32388;

   localparam logic [COORD_W-1:0] SAT_POS = 32'h7fff_ffff;
   localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INV_DEPTH_SCALE = 3'd0,
      CSR_CENTER_X        = 3'd1,
      CSR_CENTER_Y        = 3'd2,
      CSR_INV_FOCAL_X     = 3'd3,
      CSR_INV_FOCAL_Y     = 3'd4
   } csr_index_type;

   // input word, column in the lowest bits
   typedef struct packed {
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [DEPTH_W-1:0] depth;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   column;
   } req_word_type;

   // output word, point_x in the lowest bits
   typedef struct packed {
      logic [CHAN_W-1:0]  out_blue;
      logic [CHAN_W-1:0]  out_green;
      logic [CHAN_W-1:0]  out_red;
      logic [COORD_W-1:0] point_z;
      logic [COORD_W-1:0] point_y;
      logic [COORD_W-1:0] point_x;
   } rsp_word_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } color_type;

endpackage

// ----- rtl/core/depth_pixel_back_projection_unit.sv -----
// pinhole back-projection of an rgb-d pixel stream into colored 3d points
//
// req_* carries one pixel per word: column, row, raw depth and bgr color.
// rsp_* carries one point per word: x, y, z in signed q16.16 meters
// (saturated) and the pixel's red, green and blue.
// csr_* writes the camera registers by index; csr_ready is always high and
// a write should only be made while no pixel is in flight.
// pixels on an odd row or odd column, outside the image or with zero depth
// make no point; they leave a bubble in the pipe and nothing on rsp_*.
// six register stages: a pixel taken into stage 1 moves through them in order
// to rsp_*. one pixel per cycle is taken while rsp_tready stays high.
// each stage moves on when it is empty or the stage after it moves, so a
// stalled rsp_tready holds the last word and fills empty stages behind it;
// req_tready drops only once every stage holds a live pixel.
// reset clears all stage valid bits and loads the register defaults.
module depth_pixel_back_projection_unit #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   // column[11:0], row[23:12], depth[39:24], blue[47:40], green[55:48], red[63:56]
   input  logic [dpbp_pkg::IN_W-1:0]        req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // point_x[31:0], point_y[63:32], point_z[95:64],
   // out_red[103:96], out_green[111:104], out_blue[119:112]
   output logic [dpbp_pkg::OUT_W-1:0]       rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dpbp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dpbp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import dpbp_pkg::*;

   localparam int NSTAGE = 6;

   // sign and magnitude of pix*16 - center
   function automatic logic [DMAG_W:0] offset_mag(
      input logic [COL_W-1:0]    pix,
      input logic [CENTER_W-1:0] center
   );
      logic [DMAG_W-1:0] scaled;
      logic              neg;
      scaled = {pix, 4'b0000};
      neg    = center > scaled;
      return {neg, neg ? DMAG_W'(center - scaled) : DMAG_W'(scaled - center)};
   endfunction

   // apply the sign and clamp to the signed 32-bit range
   function automatic logic [COORD_W-1:0] lat_sat(
      input logic [MAG_W-1:0] mag,
      input logic             neg
   );
      logic [COORD_W-1:0] res;
      if (neg) begin
         res = (mag > MAG_W'(SAT_NEG)) ? SAT_NEG : COORD_W'(0) - mag[COORD_W-1:0];
      end else begin
         res = (mag > MAG_W'(SAT_POS)) ? SAT_POS : mag[COORD_W-1:0];
      end
      return res;
   endfunction

   // camera registers
   logic [SCALE_W-1:0]  inv_depth_scale_ff;
   logic [CENTER_W-1:0] center_x_ff;
   logic [CENTER_W-1:0] center_y_ff;
   logic [FOCAL_W-1:0]  inv_focal_x_ff;
   logic [FOCAL_W-1:0]  inv_focal_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_depth_scale_ff <= INV_DEPTH_SCALE_RST;
         center_x_ff        <= CENTER_X_RST;
         center_y_ff        <= CENTER_Y_RST;
         inv_focal_x_ff     <= INV_FOCAL_X_RST;
         inv_focal_y_ff     <= INV_FOCAL_Y_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_INV_DEPTH_SCALE: inv_depth_scale_ff <= csr_data[SCALE_W-1:0];
            CSR_CENTER_X:        center_x_ff        <= csr_data[CENTER_W-1:0];
            CSR_CENTER_Y:        center_y_ff        <= csr_data[CENTER_W-1:0];
            CSR_INV_FOCAL_X:     inv_focal_x_ff     <= csr_data[FOCAL_W-1:0];
            CSR_INV_FOCAL_Y:     inv_focal_y_ff     <= csr_data[FOCAL_W-1:0];
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   // stage valid bits and the per-stage move enables
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] vld_in;
   logic [NSTAGE-1:0] adv;

   always_comb begin
      adv[NSTAGE-1] = !vld_ff[NSTAGE-1] || rsp_tready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_tready = adv[0];

   // input filter: even row and column, inside the image, depth present
   req_word_type req_word;
   logic         pix_keep;

   assign req_word = req_tdata;

   always_comb begin
      pix_keep = ({1'b0, req_word.column} < (COL_W + 1)'(MAX_WIDTH))
              && ({1'b0, req_word.row} < (ROW_W + 1)'(MAX_HEIGHT))
              && !req_word.column[0]
              && !req_word.row[0]
              && (req_word.depth != '0);
   end

   always_comb begin
      vld_in[0] = req_tvalid && pix_keep;
      for (int k = 1; k < NSTAGE; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // stage 1: registered pixel
   logic [COL_W-1:0]   col_s1_ff;
   logic [ROW_W-1:0]   row_s1_ff;
   logic [DEPTH_W-1:0] depth_s1_ff;
   color_type          color_s1_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         col_s1_ff         <= req_word.column;
         row_s1_ff         <= req_word.row;
         depth_s1_ff       <= req_word.depth;
         color_s1_ff.red   <= req_word.red;
         color_s1_ff.green <= req_word.green;
         color_s1_ff.blue  <= req_word.blue;
      end
   end

   // stage 2: depth times 1/scale, offsets from the principal point
   logic [ZF_W-1:0]   zf_s2_ff;
   logic [ZF_W-1:0]   zf_s2_in;
   logic [DMAG_W:0]   dx_s2_ff;
   logic [DMAG_W:0]   dx_s2_in;
   logic [DMAG_W:0]   dy_s2_ff;
   logic [DMAG_W:0]   dy_s2_in;
   color_type         color_s2_ff;

   assign zf_s2_in = ZF_W'(depth_s1_ff) * ZF_W'(inv_depth_scale_ff);
   assign dx_s2_in = offset_mag(col_s1_ff, center_x_ff);
   assign dy_s2_in = offset_mag(row_s1_ff, center_y_ff);

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         zf_s2_ff    <= zf_s2_in;
         dx_s2_ff    <= dx_s2_in;
         dy_s2_ff    <= dy_s2_in;
         color_s2_ff <= color_s1_ff;
      end
   end

   // stage 3: offset times 1/f, z rounded and clamped
   logic [AX_W-1:0]    ax_s3_ff;
   logic [AX_W-1:0]    ax_s3_in;
   logic [AX_W-1:0]    ay_s3_ff;
   logic [AX_W-1:0]    ay_s3_in;
   logic               xneg_s3_ff;
   logic               yneg_s3_ff;
   logic [ZF_W-1:0]    zf_s3_ff;
   logic [COORD_W-1:0] z_s3_ff;
   logic [COORD_W-1:0] z_s3_in;
   logic [ZR_W-1:0]    z_round;
   logic [ZQ_W-1:0]    z_quot;
   color_type          color_s3_ff;

   assign ax_s3_in = AX_W'(dx_s2_ff[DMAG_W-1:0]) * AX_W'(inv_focal_x_ff);
   assign ay_s3_in = AX_W'(dy_s2_ff[DMAG_W-1:0]) * AX_W'(inv_focal_y_ff);

   always_comb begin
      // half-up rounding of q24.24 down to q16.16
      z_round = {1'b0, zf_s2_ff} + ZR_W'(1 << (Z_SHIFT - 1));
      z_quot  = z_round[ZR_W-1:Z_SHIFT];
      z_s3_in = (z_quot > ZQ_W'(SAT_POS)) ? SAT_POS : z_quot[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         ax_s3_ff    <= ax_s3_in;
         ay_s3_ff    <= ay_s3_in;
         xneg_s3_ff  <= dx_s2_ff[DMAG_W];
         yneg_s3_ff  <= dy_s2_ff[DMAG_W];
         zf_s3_ff    <= zf_s2_ff;
         z_s3_ff     <= z_s3_in;
         color_s3_ff <= color_s2_ff;
      end
   end

   // stage 4: partial products against the low and high halves of z
   logic [PP_W-1:0]    pxl_s4_ff;
   logic [PP_W-1:0]    pxh_s4_ff;
   logic [PP_W-1:0]    pyl_s4_ff;
   logic [PP_W-1:0]    pyh_s4_ff;
   logic               xneg_s4_ff;
   logic               yneg_s4_ff;
   logic [COORD_W-1:0] z_s4_ff;
   color_type          color_s4_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         pxl_s4_ff   <= PP_W'(ax_s3_ff) * PP_W'(zf_s3_ff[ZF_HALF_W-1:0]);
         pxh_s4_ff   <= PP_W'(ax_s3_ff) * PP_W'(zf_s3_ff[ZF_W-1:ZF_HALF_W]);
         pyl_s4_ff   <= PP_W'(ay_s3_ff) * PP_W'(zf_s3_ff[ZF_HALF_W-1:0]);
         pyh_s4_ff   <= PP_W'(ay_s3_ff) * PP_W'(zf_s3_ff[ZF_W-1:ZF_HALF_W]);
         xneg_s4_ff  <= xneg_s3_ff;
         yneg_s4_ff  <= yneg_s3_ff;
         z_s4_ff     <= z_s3_ff;
         color_s4_ff <= color_s3_ff;
      end
   end

   // stage 5: sum the halves, round half away from zero, drop 36 fraction bits
   logic [PROD_W-1:0]  x_sum;
   logic [PROD_W-1:0]  y_sum;
   logic [MAG_W-1:0]   xmag_s5_ff;
   logic [MAG_W-1:0]   ymag_s5_ff;
   logic               xneg_s5_ff;
   logic               yneg_s5_ff;
   logic [COORD_W-1:0] z_s5_ff;
   color_type          color_s5_ff;

   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_SHIFT - 1);

   always_comb begin
      x_sum = PROD_W'(pxl_s4_ff) + {pxh_s4_ff, {ZF_HALF_W{1'b0}}} + ROUND_HALF;
      y_sum = PROD_W'(pyl_s4_ff) + {pyh_s4_ff, {ZF_HALF_W{1'b0}}} + ROUND_HALF;
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         xmag_s5_ff  <= x_sum[PROD_W-1:FRAC_SHIFT];
         ymag_s5_ff  <= y_sum[PROD_W-1:FRAC_SHIFT];
         xneg_s5_ff  <= xneg_s4_ff;
         yneg_s5_ff  <= yneg_s4_ff;
         z_s5_ff     <= z_s4_ff;
         color_s5_ff <= color_s4_ff;
      end
   end

   // stage 6: sign, clamp and the output word
   rsp_word_type rsp_s6_ff;

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         rsp_s6_ff.point_x   <= lat_sat(xmag_s5_ff, xneg_s5_ff);
         rsp_s6_ff.point_y   <= lat_sat(ymag_s5_ff, yneg_s5_ff);
         rsp_s6_ff.point_z   <= z_s5_ff;
         rsp_s6_ff.out_red   <= color_s5_ff.red;
         rsp_s6_ff.out_green <= color_s5_ff.green;
         rsp_s6_ff.out_blue  <= color_s5_ff.blue;
      end
   end

   assign rsp_tdata  = rsp_s6_ff;
   assign rsp_tvalid = vld_ff[NSTAGE-1];

endmodule

// ----- rtl/core/dpbp_checker.sv -----
// port-level checks of the back-projection unit and their bind
`include "depth_pixel_back_projection_unit_macros.svh"

module dpbp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic [dpbp_pkg::OUT_W-1:0]  rsp_tdata,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready
);
   import dpbp_pkg::*;

   // reset empties the whole pipe
   `DPBP_ASSERT_NEXT_ALWAYS(a_reset_empties, reset, !rsp_tvalid)

   // depth is never negative
   `DPBP_ASSERT_SAME(a_z_not_negative, rsp_tvalid, !rsp_tdata[Z_MSB])

   // a stalled word stays put
   `DPBP_ASSERT_NEXT(a_stall_holds_valid, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `DPBP_ASSERT_NEXT(a_stall_holds_data, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

endmodule

bind depth_pixel_back_projection_unit dpbp_checker u_dpbp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

// ----- sim/depth_pixel_back_projection_unit_tb.sv -----
// self-checking testbench of the depth pixel back-projection unit
module depth_pixel_back_projection_unit_tb;
   import dpbp_pkg::*;

   // drain time after the last point: six stages plus margin
   localparam int PIPE_FLUSH      = 12;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 62;
   localparam int NUM_PHASES      = 20;
   // long output hold-off, well beyond the pipe depth
   localparam int HOLD_CYCLES     = 300;
   localparam int MAX_REPORTS     = 40;
   // first index past the register list; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = 3'd5;

   // kinds of rows in the directed table
   typedef enum {
      STEP_CSR,
      STEP_PIXEL,
      STEP_NO_POINT,
      STEP_POINT
   } step_kind_type;

   // camera register settings used by the random phases
   typedef enum {
      CAM_DEFAULT,
      CAM_REALISTIC,
      CAM_ALL_ONES,
      CAM_SMALL,
      CAM_RANDOM
   } camera_setting_type;

   typedef struct {
      step_kind_type        kind;
      logic [CSR_IDX_W-1:0] index;
      logic [CSR_DATA_W-1:0] value;
      req_word_type         pix;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic [COORD_W-1:0]   z;
   } directed_step_type;

   logic                  clock;
   logic                  reset;
   req_word_type          req_tdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [OUT_W-1:0]      rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // shadow of the camera registers, kept by the scoreboard
   logic [SCALE_W-1:0]  cam_scale;
   logic [CENTER_W-1:0] cam_cx;
   logic [CENTER_W-1:0] cam_cy;
   logic [FOCAL_W-1:0]  cam_fx;
   logic [FOCAL_W-1:0]  cam_fy;

   rsp_word_type pending_points[$];

   // directed rows with a typed-in answer bypass the predictor
   bit           typed_on;
   bit           typed_has;
   rsp_word_type typed_point;

   int send_idle_pct;
   int recv_stall_pct;
   int rsp_hold_left;
   int cycle_count;
   int error_count;
   int pixels_taken;
   int points_checked;
   int settings_applied;

   directed_step_type steps[$];

   depth_pixel_back_projection_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit; a hang anywhere ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d points still owed", cycle_count,
                  pending_points.size());
         $display("depth_pixel_back_projection_unit regression: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_REPORTS)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [COORD_W-1:0] got,
                                input logic [COORD_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // lateral coordinate: (pix*16 - center) * inv_focal * zf, one rounding at 2^-36
   function automatic logic [COORD_W-1:0] lateral_coord(input logic [11:0] pix,
                                                        input logic [CENTER_W-1:0] center,
                                                        input logic [FOCAL_W-1:0] inv_focal,
                                                        input logic [ZF_W-1:0] zf);
      logic [15:0]         scaled;
      logic                neg;
      logic [DMAG_W-1:0]   offset_mag;
      logic [AX_W-1:0]     offset_scaled;
      logic [PROD_W-1:0]   prod;
      logic [MAG_W-1:0]    mag;
      scaled        = {pix, 4'b0000};
      neg           = center > scaled;
      offset_mag    = neg ? center - scaled : scaled - center;
      offset_scaled = offset_mag * inv_focal;
      prod          = offset_scaled * zf;
      // half away from zero on the magnitude
      prod          = prod + ({{(PROD_W-1){1'b0}}, 1'b1} << (FRAC_SHIFT - 1));
      mag           = prod[PROD_W-1:FRAC_SHIFT];
      if (neg) begin
         if (mag > {{(MAG_W-COORD_W){1'b0}}, SAT_NEG})
            return SAT_NEG;
         return COORD_W'(0) - mag[COORD_W-1:0];
      end
      if (mag > {{(MAG_W-COORD_W){1'b0}}, SAT_POS})
         return SAT_POS;
      return mag[COORD_W-1:0];
   endfunction

   // expected point for one pixel under the current camera registers
   function automatic rsp_word_type project_pixel(input req_word_type pix,
                                                  output bit gives_point);
      rsp_word_type        pt;
      logic [ZF_W-1:0]     zf;
      logic [ZR_W-1:0]     zr;
      pt          = '0;
      gives_point = pix.column[0] == 1'b0 && pix.row[0] == 1'b0 && pix.depth != '0;
      zf          = pix.depth * cam_scale;
      zr          = {1'b0, zf} + ZR_W'(128);
      zr          = zr >> Z_SHIFT;
      pt.point_z  = (zr > {{(ZR_W-COORD_W){1'b0}}, SAT_POS}) ? SAT_POS : zr[COORD_W-1:0];
      pt.point_x  = lateral_coord(pix.column, cam_cx, cam_fx, zf);
      pt.point_y  = lateral_coord(pix.row, cam_cy, cam_fy, zf);
      pt.out_red   = pix.red;
      pt.out_green = pix.green;
      pt.out_blue  = pix.blue;
      return pt;
   endfunction

   // scoreboard: checks points, predicts pixels, tracks register writes
   always @(posedge clock) begin : scoreboard
      rsp_word_type got;
      rsp_word_type want;
      rsp_word_type guess;
      bit           gives_point;
      if (reset) begin
         cam_scale = INV_DEPTH_SCALE_RST;
         cam_cx    = CENTER_X_RST;
         cam_cy    = CENTER_Y_RST;
         cam_fx    = INV_FOCAL_X_RST;
         cam_fy    = INV_FOCAL_Y_RST;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_word_type'(rsp_tdata);
            if (pending_points.size() == 0) begin
               report_mismatch($sformatf("point with no pixel owed: x=%h y=%h z=%h",
                                         got.point_x, got.point_y, got.point_z));
            end else begin
               want = pending_points.pop_front();
               compare_field("point_x", got.point_x, want.point_x);
               compare_field("point_y", got.point_y, want.point_y);
               compare_field("point_z", got.point_z, want.point_z);
               compare_field("out_red", 32'(got.out_red), 32'(want.out_red));
               compare_field("out_green", 32'(got.out_green), 32'(want.out_green));
               compare_field("out_blue", 32'(got.out_blue), 32'(want.out_blue));
               points_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            pixels_taken++;
            if (typed_on) begin
               if (typed_has)
                  pending_points.insert(pending_points.size(), typed_point);
            end else begin
               guess = project_pixel(req_tdata, gives_point);
               if (gives_point)
                  pending_points.insert(pending_points.size(), guess);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INV_DEPTH_SCALE: cam_scale = csr_data[SCALE_W-1:0];
               CSR_CENTER_X:        cam_cx    = csr_data[CENTER_W-1:0];
               CSR_CENTER_Y:        cam_cy    = csr_data[CENTER_W-1:0];
               CSR_INV_FOCAL_X:     cam_fx    = csr_data[FOCAL_W-1:0];
               CSR_INV_FOCAL_Y:     cam_fy    = csr_data[FOCAL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // receiver: random stalls, plus a long hold-off counted down here
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_left--;
         end else if (recv_stall_pct == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic offer_pixel(input req_word_type pix);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // register write, then an idle gap so valid never toggles within a step
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // stop sending, wait for every owed point, then let dropped pixels leave the pipe
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0)
         @(posedge clock);
      repeat (PIPE_FLUSH) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_camera(input camera_setting_type kind);
      logic [CSR_DATA_W-1:0] v [5];
      case (kind)
         CAM_DEFAULT: begin
            v[0] = INV_DEPTH_SCALE_RST;
            v[1] = CSR_DATA_W'(CENTER_X_RST);
            v[2] = CSR_DATA_W'(CENTER_Y_RST);
            v[3] = CSR_DATA_W'(INV_FOCAL_X_RST);
            v[4] = CSR_DATA_W'(INV_FOCAL_Y_RST);
         end
         CAM_REALISTIC: begin
            // depth units 0.2 mm to 4 mm, focal 190 to 2000 pixels
            v[0] = $urandom_range(70000, 3000);
            v[1] = $urandom_range(65535);
            v[2] = $urandom_range(65535);
            v[3] = $urandom_range(90000, 8000);
            v[4] = $urandom_range(90000, 8000);
         end
         CAM_ALL_ONES: begin
            v[0] = '1;
            v[1] = '1;
            v[2] = '1;
            v[3] = '1;
            v[4] = '1;
         end
         CAM_SMALL: begin
            v[0] = $urandom_range(255);
            v[1] = $urandom_range(65535);
            v[2] = $urandom_range(65535);
            v[3] = $urandom_range(255);
            v[4] = $urandom_range(255);
         end
         default: begin
            // full words; the unit keeps only the register width
            v[0] = $urandom;
            v[1] = $urandom;
            v[2] = $urandom;
            v[3] = $urandom;
            v[4] = $urandom;
            write_csr(CSR_IDX_W'($urandom_range(2**CSR_IDX_W - 1, CSR_FIRST_UNUSED)),
                      $urandom);
         end
      endcase
      write_csr(CSR_INV_DEPTH_SCALE, v[0]);
      write_csr(CSR_CENTER_X, v[1]);
      write_csr(CSR_CENTER_Y, v[2]);
      write_csr(CSR_INV_FOCAL_X, v[3]);
      write_csr(CSR_INV_FOCAL_Y, v[4]);
      settings_applied++;
   endtask

   // mostly valid even-grid pixels with depth, some with zero depth, the rest noise
   function automatic req_word_type random_pixel();
      req_word_type w;
      int           pick;
      w    = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 80) begin
         w.column[0] = 1'b0;
         w.row[0]    = 1'b0;
      end
      if (pick < 8) begin
         w.column = $urandom_range(1) ? '0 : 12'd4094;
         w.row    = $urandom_range(1) ? '0 : 12'd4094;
      end
      if (pick < 75) begin
         case ($urandom_range(9))
            0:       w.depth = '1;
            1:       w.depth = 16'd1;
            2, 3:    w.depth = 16'($urandom_range(8000, 300));
            default: if (w.depth == '0) w.depth = 16'd1;
         endcase
      end else if (pick < 80) begin
         w.depth = '0;
      end
      return w;
   endfunction

   function automatic directed_step_type csr_step(input logic [CSR_IDX_W-1:0] idx,
                                                  input logic [CSR_DATA_W-1:0] value);
      directed_step_type s;
      s       = '{default: '0, kind: STEP_CSR};
      s.index = idx;
      s.value = value;
      return s;
   endfunction

   function automatic directed_step_type pixel_step(input step_kind_type kind,
                                                    input logic [11:0] col,
                                                    input logic [11:0] row,
                                                    input logic [15:0] depth,
                                                    input logic [23:0] bgr,
                                                    input logic [31:0] x = '0,
                                                    input logic [31:0] y = '0,
                                                    input logic [31:0] z = '0);
      directed_step_type s;
      s                 = '{default: '0, kind: STEP_PIXEL};
      s.kind            = kind;
      s.pix.column      = col;
      s.pix.row         = row;
      s.pix.depth       = depth;
      {s.pix.red, s.pix.green, s.pix.blue} = bgr;
      s.x               = x;
      s.y               = y;
      s.z               = z;
      return s;
   endfunction

   // append one row to the directed table
   task automatic add_step(input directed_step_type s);
      steps.insert(steps.size(), s);
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      typed_on       = 1'b0;
      typed_has      = 1'b0;
      typed_point    = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      rsp_hold_left  = 0;
      settings_applied = 0;

      // directed table, default camera first
      add_step(pixel_step(STEP_PIXEL, 12'd0, 12'd0, 16'd1, 24'h000000));
      add_step(pixel_step(STEP_PIXEL, 12'd4094, 12'd4094, 16'hffff, 24'hffffff));
      // odd column, odd row, outside the even grid at the far corner, zero depth
      add_step(pixel_step(STEP_NO_POINT, 12'd1, 12'd0, 16'd100, 24'h123456));
      add_step(pixel_step(STEP_NO_POINT, 12'd0, 12'd1, 16'd100, 24'h654321));
      add_step(pixel_step(STEP_NO_POINT, 12'd4095, 12'd4095, 16'hffff, 24'hffffff));
      add_step(pixel_step(STEP_NO_POINT, 12'd2, 12'd2, 16'd0, 24'h0f0f0f));
      // near the principal point, both sides
      add_step(pixel_step(STEP_PIXEL, 12'd324, 12'd254, 16'd1000, 24'h808080));
      add_step(pixel_step(STEP_PIXEL, 12'd326, 12'd252, 16'd1000, 24'h7f7f7f));
      add_step(pixel_step(STEP_PIXEL, 12'haaa, 12'h554, 16'haaaa, 24'ha5a55a));
      add_step(pixel_step(STEP_PIXEL, 12'h554, 12'haaa, 16'h5555, 24'h5a5aa5));
      // every register at its top: all three coordinates saturate
      add_step(csr_step(CSR_INV_DEPTH_SCALE, '1));
      add_step(csr_step(CSR_CENTER_X, '1));
      add_step(csr_step(CSR_CENTER_Y, '1));
      add_step(csr_step(CSR_INV_FOCAL_X, '1));
      add_step(csr_step(CSR_INV_FOCAL_Y, '1));
      add_step(pixel_step(STEP_POINT, 12'd0, 12'd0, 16'hffff, 24'h010203,
                          SAT_NEG, SAT_NEG, SAT_POS));
      add_step(pixel_step(STEP_POINT, 12'd4094, 12'd4094, 16'hffff, 24'hfefdfc,
                          SAT_NEG, SAT_NEG, SAT_POS));
      // center at zero, written with junk above the field width
      add_step(csr_step(CSR_CENTER_X, 32'hffff_0000));
      add_step(csr_step(CSR_CENTER_Y, 32'hffff_0000));
      add_step(pixel_step(STEP_POINT, 12'd4094, 12'd4094, 16'hffff, 24'h00ff00,
                          SAT_POS, SAT_POS, SAT_POS));
      add_step(pixel_step(STEP_POINT, 12'd0, 12'd0, 16'hffff, 24'hff00ff,
                          32'd0, 32'd0, SAT_POS));
      // writes past the register list change nothing
      for (int i = CSR_FIRST_UNUSED; i < 2**CSR_IDX_W; i++)
         add_step(csr_step(CSR_IDX_W'(i), '0));
      add_step(pixel_step(STEP_POINT, 12'd4094, 12'd4094, 16'hffff, 24'h336699,
                          SAT_POS, SAT_POS, SAT_POS));
      // zero scale and focal: the point collapses to the origin
      add_step(csr_step(CSR_INV_DEPTH_SCALE, '0));
      add_step(csr_step(CSR_INV_FOCAL_X, '0));
      add_step(csr_step(CSR_INV_FOCAL_Y, '0));
      add_step(pixel_step(STEP_POINT, 12'd4094, 12'd4094, 16'hffff, 24'h996633,
                          32'd0, 32'd0, 32'd0));
      add_step(pixel_step(STEP_NO_POINT, 12'd3, 12'd2, 16'd5, 24'h112233));
      // back to the reset values, focal x with junk in the top byte
      add_step(csr_step(CSR_INV_DEPTH_SCALE, INV_DEPTH_SCALE_RST));
      add_step(csr_step(CSR_CENTER_X, CSR_DATA_W'(CENTER_X_RST)));
      add_step(csr_step(CSR_CENTER_Y, CSR_DATA_W'(CENTER_Y_RST)));
      add_step(csr_step(CSR_INV_FOCAL_X, {8'hff, INV_FOCAL_X_RST}));
      add_step(csr_step(CSR_INV_FOCAL_Y, CSR_DATA_W'(INV_FOCAL_Y_RST)));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (steps[i]) begin
         if (steps[i].kind == STEP_CSR) begin
            settle();
            write_csr(steps[i].index, steps[i].value);
         end else begin
            typed_on                = steps[i].kind != STEP_PIXEL;
            typed_has               = steps[i].kind == STEP_POINT;
            typed_point.point_x     = steps[i].x;
            typed_point.point_y     = steps[i].y;
            typed_point.point_z     = steps[i].z;
            typed_point.out_red     = steps[i].pix.red;
            typed_point.out_green   = steps[i].pix.green;
            typed_point.out_blue    = steps[i].pix.blue;
            offer_pixel(steps[i].pix);
         end
      end
      settle();
      typed_on = 1'b0;

      // random phases: handshake pattern cycles fastest, camera setting slowest
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         settle();
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         set_camera(camera_setting_type'(phase / 4));
         // output held off while pixels keep coming, so the pipe backs up
         if (phase % 8 == 4)
            rsp_hold_left = HOLD_CYCLES;
         repeat (ITEMS_PER_PHASE) offer_pixel(random_pixel());
      end
      settle();

      $display("covered %0d pixels giving %0d points over %0d camera register loads",
               pixels_taken, points_checked, settings_applied);
      $display("handshakes: free running, sender gaps, receiver stalls, both, long hold-off");
      if (error_count == 0) begin
         $display("depth_pixel_back_projection_unit regression: pass");
      end else begin
         $display("%0d mismatches", error_count);
         $display("depth_pixel_back_projection_unit regression: fail");
      end
      $finish;
   end

endmodule
